[hw/rtl/bounded_deque_with_ordered_insert_defines.svh]
// Assertion macros used by the deque top level.
`ifndef BOUNDED_DEQUE_WITH_ORDERED_INSERT_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_ORDERED_INSERT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bdq_pkg.sv]
// Types and codes shared by the deque modules.
package bdq_pkg;

  localparam int unsigned VALUE_W = 32;

  // operation codes carried in the kind field
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_ORDERED    = 3'd2;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
  localparam logic [2:0] KIND_POP_BACK   = 3'd4;
  localparam logic [2:0] KIND_REMOVE     = 3'd5;

  // result status codes
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_EMPTY     = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]                kind;
    logic signed [VALUE_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] popped_value;
    logic [4:0]                entry_count;
    logic                      is_empty;
    logic                      is_full;
  } out_item_t;

  // what a cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                      cmp_en;
    logic [2:0]                kind;
    logic signed [VALUE_W-1:0] key;
  } cell_ctrl_t;

endpackage

[hw/rtl/bounded_deque_with_ordered_insert.sv]
// Top level of the bounded deque with ordered insert.
// Usage
//   Input channel: in_valid_i / in_stall_o carry one item (kind, item_value). An item
//   is taken at a rising edge with in_valid_i high and in_stall_o low.
//   Output channel: out_valid_o / out_stall_i carry one result item (status, popped
//   value, count, empty, full) for every input item, in order.
//   Storage is a row of CAPACITY cells; cell 0 is the front. Every cell compares its
//   own value against the key, then in a single step the cells from the first match on
//   shift toward the back or the front, each from a neighbor (or the key); others hold.
// Timing
//   An item moves through accept, per-cell compare into a flag register, then
//   prefix OR over the flags plus the shift and result load, which registers the
//   result in the output register. A new item is taken only after the previous one
//   has finished its shift step; in_stall_o is high until then.
// Reset
//   rst_ni clears the count and the handshake state; cell contents are not cleared
//   and are never read before being written.
// Backpressure
//   A waiting result sits in the output register. The next item is still taken and
//   compared; its shift step waits until the output register is free.
`include "bounded_deque_with_ordered_insert_defines.svh"

module bounded_deque_with_ordered_insert #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bdq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bdq_pkg::out_item_t out_item_o
);
  import bdq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_e;

  state_e state_q;

  // item under work
  logic [2:0]                kind_q;
  logic signed [VALUE_W-1:0] key_q;
  logic [CNT_W-1:0]          count_q, count_d;

  logic      out_valid_q;
  out_item_t out_item_q, out_item_d;

  // cell row
  cell_ctrl_t                cell_ctrl;
  cell_op_e                  cell_op  [CAPACITY];
  logic signed [VALUE_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]       match, prefix, first;

  logic in_accept, out_free, apply_go;
  logic is_ins, is_pop, is_rem_kind, full_now, empty_now, found;
  logic do_ins, do_rem;
  logic signed [VALUE_W-1:0] sel_val;
  logic [CNT_W+4:0] cnt_ext;

  assign in_accept = in_valid_i & ~in_stall_o;
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign apply_go  = (state_q == ST_APPLY) & out_free;

  assign cell_ctrl.cmp_en = (state_q == ST_CMP);
  assign cell_ctrl.kind   = kind_q;
  assign cell_ctrl.key    = key_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_v, right_v;
    if (i == 0) begin : g_head
      assign left_v = key_q;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end

    bdq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .count_i (count_q),
      .op_i    (cell_op[i]),
      .left_i  (left_v),
      .right_i (right_v),
      .value_o (cell_val[i]),
      .match_o (match[i])
    );
  end

  bdq_prefix_or #(
    .N (CAPACITY)
  ) u_prefix (
    .flags_i  (match),
    .prefix_o (prefix)
  );

  // one-hot of the first matching cell
  assign first = match & ~{prefix[CAPACITY-2:0], 1'b0};

  assign full_now  = (count_q == CAP_C);
  assign empty_now = (count_q == '0);
  assign found     = prefix[CAPACITY-1];

  assign is_ins = (kind_q == KIND_PUSH_FRONT) || (kind_q == KIND_PUSH_BACK) ||
                  (kind_q == KIND_ORDERED);
  assign is_pop = (kind_q == KIND_POP_FRONT) || (kind_q == KIND_POP_BACK);
  assign is_rem_kind = is_pop || (kind_q == KIND_REMOVE);

  assign do_ins = is_ins & ~full_now;
  assign do_rem = is_rem_kind & ~empty_now & found;

  // per-cell shift control
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_op[i] = CELL_HOLD;
      if (apply_go && do_ins) begin
        if (first[i]) begin
          cell_op[i] = CELL_LOAD;
        end else if (prefix[i]) begin
          cell_op[i] = CELL_FROM_LEFT;
        end
      end else if (apply_go && do_rem && prefix[i]) begin
        cell_op[i] = CELL_FROM_RIGHT;
      end
    end
  end

  // value of the cell being popped (one-hot select)
  always_comb begin
    sel_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_val = sel_val | (cell_val[i] & {VALUE_W{first[i]}});
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + ONE_C;
    end else if (do_rem) begin
      count_d = count_q - ONE_C;
    end
  end

  assign cnt_ext = {5'b0, count_d};

  always_comb begin
    priority if (is_ins && full_now) begin
      out_item_d.status = STATUS_FULL;
    end else if (is_rem_kind && empty_now) begin
      out_item_d.status = STATUS_EMPTY;
    end else if ((kind_q == KIND_REMOVE) && !found) begin
      out_item_d.status = STATUS_NOT_FOUND;
    end else begin
      out_item_d.status = STATUS_DONE;
    end
    out_item_d.popped_value = (is_pop && do_rem) ? sel_val : '0;
    out_item_d.entry_count  = cnt_ext[4:0];
    out_item_d.is_empty     = (count_d == '0);
    out_item_d.is_full      = (count_d == CAP_C);
  end

  // handshake state, count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      // a taken result frees the register unless a new one lands this cycle
      if (out_valid_q && !out_stall_i && !apply_go) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          state_q <= ST_APPLY;
        end
        ST_APPLY: begin
          if (out_free) begin
            count_q     <= count_d;
            out_valid_q <= 1'b1;
            out_item_q  <= out_item_d;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // item under work
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= in_item_i.kind;
      key_q  <= in_item_i.item_value;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `BDQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CAP_C, "count above capacity")
  `BDQ_ASSERT_NEXT(a_count_only_apply, state_q != ST_APPLY, $stable(count_q),
                   "count moved outside apply")
  `BDQ_ASSERT_NOW(a_valid_from_apply, $rose(out_valid_q), $past(state_q) == ST_APPLY,
                  "result without apply")
  `BDQ_ASSERT_NEXT(a_apply_waits, (state_q == ST_APPLY) && out_valid_q && out_stall_i,
                   state_q == ST_APPLY, "apply overran a held result")
  `BDQ_ASSERT_NOW(a_pop_zero, out_valid_q && (out_item_q.status != STATUS_DONE),
                  out_item_q.popped_value == '0, "refused item carries a value")

endmodule

[hw/rtl/bdq_cell.sv]
// One deque slot: stored value, local match flag and neighbor shift mux.
module bdq_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                              clk_i,
  input  bdq_pkg::cell_ctrl_t               ctrl_i,
  input  logic [CNT_W-1:0]                  count_i,
  input  bdq_pkg::cell_op_e                 op_i,
  input  logic signed [bdq_pkg::VALUE_W-1:0] left_i,
  input  logic signed [bdq_pkg::VALUE_W-1:0] right_i,
  output logic signed [bdq_pkg::VALUE_W-1:0] value_o,
  output logic                              match_o
);
  import bdq_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);
  localparam bit               IS_HEAD = (IDX == 0);

  logic signed [VALUE_W-1:0] value_q, value_d;
  logic                      match_q, match_d;
  logic                      below, at_tail, is_last, ge, eq;

  assign below   = count_i > IDX_C;
  assign at_tail = count_i == IDX_C;
  assign is_last = count_i == NEXT_C;
  assign ge      = value_q >= ctrl_i.key;
  assign eq      = value_q == ctrl_i.key;

  always_comb begin
    unique case (ctrl_i.kind)
      KIND_PUSH_FRONT, KIND_POP_FRONT: match_d = IS_HEAD;
      KIND_PUSH_BACK:                  match_d = at_tail;
      KIND_ORDERED:                    match_d = at_tail | (below & ge);
      KIND_POP_BACK:                   match_d = is_last;
      KIND_REMOVE:                     match_d = below & eq;
      default:                         match_d = 1'b0;
    endcase
  end

  always_comb begin
    unique case (op_i)
      CELL_HOLD:       value_d = value_q;
      CELL_LOAD:       value_d = ctrl_i.key;
      CELL_FROM_LEFT:  value_d = left_i;
      CELL_FROM_RIGHT: value_d = right_i;
      default:         value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    if (ctrl_i.cmp_en) begin
      match_q <= match_d;
    end
  end

  assign value_o = value_q;
  assign match_o = match_q;

endmodule

[hw/rtl/bdq_prefix_or.sv]
// Inclusive prefix OR over the cell match flags (log-depth).
module bdq_prefix_or #(
  parameter int unsigned N = 16
) (
  input  logic [N-1:0] flags_i,
  output logic [N-1:0] prefix_o
);

  localparam int unsigned LEVELS = $clog2(N);

  logic [N-1:0] lvl [LEVELS+1];

  assign lvl[0] = flags_i;

  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << k)) begin : g_or
        assign lvl[k+1][i] = lvl[k][i] | lvl[k][i - (1 << k)];
      end else begin : g_pass
        assign lvl[k+1][i] = lvl[k][i];
      end
    end
  end

  assign prefix_o = lvl[LEVELS];

endmodule
